// ===== design/ctp_pkg.sv =====
// shared types and constants of the color table port
// request and result structs, offset codes, table word width
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ctp_pkg;

	localparam int WORD_W = 16;

	localparam logic [2:0] OFS_ADDR_LO = 3'd2;
	localparam logic [2:0] OFS_ADDR_HI = 3'd3;
	localparam logic [2:0] OFS_DATA_LO = 3'd4;
	localparam logic [2:0] OFS_DATA_HI = 3'd5;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [2:0] reg_offset;
		logic [7:0] write_byte;
	} request_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       color_valid;
		logic [8:0] color_index;
		logic [7:0] red_level;
		logic [7:0] green_level;
		logic [7:0] blue_level;
	} result_t;

endpackage

`default_nettype wire

// ===== design/ctp_table_ram.sv =====
// color table storage: one write port, one read port, registered read data
// depends on ctp_pkg for the word width
`timescale 1ns / 1ps
`default_nettype none

module ctp_table_ram #(
	parameter int DEPTH  = 512,
	parameter int ADDR_W = 9
) (
	input  wire                           clk,
	input  wire                           wr_en,
	input  wire  [ADDR_W-1:0]             wr_addr,
	input  wire  [ctp_pkg::WORD_W-1:0]    wr_data,
	input  wire                           rd_en,
	input  wire  [ADDR_W-1:0]             rd_addr,
	output logic [ctp_pkg::WORD_W-1:0]    rd_data
);

	logic [ctp_pkg::WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== design/color_table_port.sv =====
// top level of the color table port: request sequencer around the table memory
// depends on ctp_pkg and ctp_table_ram
//
// usage
//   a request (kind, reg_offset, write_byte) is taken at a rising edge with
//   start high and busy low. every request gives exactly one result, shown
//   on result for one cycle with done high; the receiver cannot stall it.
// request flow
//   address and unused offsets: result in the cycle after the request
//   data low/high byte reads and low byte writes: result after LOOKUP and MODIFY
//   data high byte writes: FETCH0 and BASE then read entry 0 and MIRROR copies
//   it into the 31 entries at stride multiples, one memory write per cycle
//   busy stays high until done; the next request may start in that cycle
// reset
//   after arst_n is released the table is cleared one entry a cycle,
//   all 512 entries with busy high; the address register starts at zero
// color events
//   a high byte write reports the addressed entry (after the copy) as
//   3-bit red, green and blue levels shifted left by five
`timescale 1ns / 1ps
`default_nettype none

module color_table_port #(
	parameter int TABLE_ENTRIES = 512,
	parameter int MIRROR_STRIDE = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  ctp_pkg::request_t  request,
	output logic               busy,
	output logic               done,
	output ctp_pkg::result_t   result
);

	localparam int AddrW   = $clog2(TABLE_ENTRIES);
	localparam int StrideW = $clog2(MIRROR_STRIDE);
	localparam int MirrorN = TABLE_ENTRIES / MIRROR_STRIDE;
	localparam int MirrorW = $clog2(MirrorN);
	localparam logic [MirrorW-1:0] MirrorLast = MirrorW'(MirrorN - 1);
	localparam logic [AddrW-1:0]   ClearLast  = AddrW'(TABLE_ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_MODIFY,
		ST_FETCH0,
		ST_BASE,
		ST_MIRROR
	} state_t;

	state_t                       state_q;
	logic [AddrW-1:0]             address_q;
	logic [AddrW-1:0]             clear_q;
	logic [MirrorW-1:0]           mirror_q;
	ctp_pkg::request_t            req_q;
	logic [ctp_pkg::WORD_W-1:0]   word_q;
	logic [ctp_pkg::WORD_W-1:0]   base_q;
	logic                         done_q;
	ctp_pkg::result_t             result_q;

	logic                         wr_en;
	logic [AddrW-1:0]             wr_addr;
	logic [ctp_pkg::WORD_W-1:0]   wr_data;
	logic                         rd_en;
	logic [AddrW-1:0]             rd_addr;
	logic [ctp_pkg::WORD_W-1:0]   rd_data;
	logic [ctp_pkg::WORD_W-1:0]   merged;
	logic [ctp_pkg::WORD_W-1:0]   report;
	logic                         accept;
	ctp_pkg::result_t             read_res;
	ctp_pkg::result_t             color_res;

	function automatic logic [7:0] level_of(input logic [2:0] bits);
		level_of = {bits, 5'b0};
	endfunction

	ctp_table_ram #(
		.DEPTH  (TABLE_ENTRIES),
		.ADDR_W (AddrW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	assign merged = (req_q.reg_offset == ctp_pkg::OFS_DATA_HI)
		? {req_q.write_byte, rd_data[7:0]}
		: {rd_data[15:8], req_q.write_byte};

	// the copy overwrites the written entry when it sits on a nonzero multiple of the stride
	assign report = (address_q[StrideW-1:0] == '0) ? base_q : word_q;

	always_comb begin
		read_res           = '0;
		read_res.read_byte = (req_q.reg_offset == ctp_pkg::OFS_DATA_HI)
			? rd_data[15:8] : rd_data[7:0];
		color_res             = '0;
		color_res.color_valid = 1'b1;
		color_res.color_index = 9'(address_q);
		color_res.red_level   = level_of(report[5:3]);
		color_res.green_level = level_of(report[8:6]);
		color_res.blue_level  = level_of(report[2:0]);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = address_q;
		wr_data = merged;
		rd_en   = 1'b0;
		rd_addr = address_q;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clear_q;
				wr_data = '0;
			end
			ST_LOOKUP: begin
				rd_en = 1'b1;
			end
			ST_MODIFY: begin
				wr_en = (req_q.kind == ctp_pkg::KIND_WRITE);
			end
			ST_FETCH0: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			ST_MIRROR: begin
				wr_en   = 1'b1;
				wr_addr = AddrW'({mirror_q, {StrideW{1'b0}}});
				wr_data = base_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			address_q <= '0;
			clear_q   <= '0;
			mirror_q  <= '0;
			req_q     <= '0;
			word_q    <= '0;
			base_q    <= '0;
			done_q    <= 1'b0;
			result_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clear_q <= clear_q + 1'b1;
					if (clear_q == ClearLast) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						req_q <= request;
						if (request.reg_offset == ctp_pkg::OFS_DATA_LO ||
							request.reg_offset == ctp_pkg::OFS_DATA_HI) begin
							state_q <= ST_LOOKUP;
						end else begin
							// address bytes and unused offsets answer at once
							result_q <= '0;
							done_q   <= 1'b1;
							if (request.kind == ctp_pkg::KIND_WRITE) begin
								case (request.reg_offset)
									ctp_pkg::OFS_ADDR_LO:
										address_q[7:0] <= request.write_byte;
									ctp_pkg::OFS_ADDR_HI:
										address_q[AddrW-1:8] <=
											(AddrW-8)'(request.write_byte[0]);
									default: begin
									end
								endcase
							end
						end
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_MODIFY;
				end
				ST_MODIFY: begin
					if (req_q.kind == ctp_pkg::KIND_READ) begin
						result_q <= read_res;
						if (req_q.reg_offset == ctp_pkg::OFS_DATA_HI) begin
							address_q <= address_q + 1'b1;
						end
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (req_q.reg_offset == ctp_pkg::OFS_DATA_HI) begin
						word_q  <= merged;
						state_q <= ST_FETCH0;
					end else begin
						result_q <= '0;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				ST_FETCH0: begin
					state_q <= ST_BASE;
				end
				ST_BASE: begin
					base_q   <= rd_data;
					mirror_q <= MirrorW'(1);
					state_q  <= ST_MIRROR;
				end
				ST_MIRROR: begin
					mirror_q <= mirror_q + 1'b1;
					if (mirror_q == MirrorLast) begin
						result_q  <= color_res;
						address_q <= address_q + 1'b1;
						done_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(accept) || $past(busy)))
		else $error("result without a request");

	a_color_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.color_valid) |-> (result.read_byte == 8'd0))
		else $error("color event outside a write result");

	a_mirror_skips_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIRROR) |-> (wr_en && wr_addr != '0))
		else $error("mirror copy aimed at entry 0");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (state_q == ST_CLEAR))
		else $error("table read and write in the same cycle");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for color_table_port: queued requests, random idle bursts
// predicts every result from a shadow copy of the table and address register
// depends on ctp_pkg and the color_table_port design
`timescale 1ns / 1ps

module testbench;

	localparam int TABLE_ENTRIES = 512;
	localparam int MIRROR_STRIDE = 16;
	localparam int RANDOM_REQUESTS = 1250;
	localparam int QUIET_TAIL = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	ctp_pkg::request_t request = '0;
	logic busy;
	logic done;
	ctp_pkg::result_t result;

	ctp_pkg::request_t pending_requests[$];
	ctp_pkg::result_t expected_results[$];
	logic [15:0] shadow_table [TABLE_ENTRIES];
	logic [8:0] shadow_addr = '0;
	int mismatches = 0;
	int gap_left = 0;

	color_table_port dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic ctp_pkg::result_t port_response(input ctp_pkg::request_t req);
		ctp_pkg::result_t res;
		logic [15:0] word;
		int i;
		res = '0;
		if (req.kind == ctp_pkg::KIND_READ) begin
			case (req.reg_offset)
				ctp_pkg::OFS_DATA_LO: res.read_byte = shadow_table[shadow_addr][7:0];
				ctp_pkg::OFS_DATA_HI: begin
					res.read_byte = shadow_table[shadow_addr][15:8];
					shadow_addr = shadow_addr + 9'd1;
				end
				default: ;
			endcase
		end else begin
			case (req.reg_offset)
				ctp_pkg::OFS_ADDR_LO: shadow_addr[7:0] = req.write_byte;
				ctp_pkg::OFS_ADDR_HI: shadow_addr[8] = req.write_byte[0];
				ctp_pkg::OFS_DATA_LO: shadow_table[shadow_addr][7:0] = req.write_byte;
				ctp_pkg::OFS_DATA_HI: begin
					shadow_table[shadow_addr][15:8] = req.write_byte;
					for (i = MIRROR_STRIDE; i < TABLE_ENTRIES; i += MIRROR_STRIDE)
						shadow_table[i] = shadow_table[0];
					word = shadow_table[shadow_addr];
					res.color_valid = 1'b1;
					res.color_index = shadow_addr;
					res.red_level = {word[5:3], 5'b0};
					res.green_level = {word[8:6], 5'b0};
					res.blue_level = {word[2:0], 5'b0};
					shadow_addr = shadow_addr + 9'd1;
				end
				default: ;
			endcase
		end
		return res;
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				expected_results.push_back(port_response(request));
			if (start && busy) begin
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left = gap_left - 1;
			end else if (pending_requests.size() > 0) begin
				if (pending_requests.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
					start <= 1'b0;
					gap_left = $urandom_range(0, 6);
				end else begin
					start <= 1'b1;
					request <= pending_requests.pop_front();
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		ctp_pkg::result_t exp_res;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result %h", result);
				mismatches++;
			end else begin
				exp_res = expected_results.pop_front();
				if (result.read_byte !== exp_res.read_byte) begin
					$error("read_byte: expected %0h, got %0h",
						exp_res.read_byte, result.read_byte);
					mismatches++;
				end
				if (result.color_valid !== exp_res.color_valid) begin
					$error("color_valid: expected %0h, got %0h",
						exp_res.color_valid, result.color_valid);
					mismatches++;
				end
				if (result.color_index !== exp_res.color_index) begin
					$error("color_index: expected %0h, got %0h",
						exp_res.color_index, result.color_index);
					mismatches++;
				end
				if (result.red_level !== exp_res.red_level) begin
					$error("red_level: expected %0h, got %0h",
						exp_res.red_level, result.red_level);
					mismatches++;
				end
				if (result.green_level !== exp_res.green_level) begin
					$error("green_level: expected %0h, got %0h",
						exp_res.green_level, result.green_level);
					mismatches++;
				end
				if (result.blue_level !== exp_res.blue_level) begin
					$error("blue_level: expected %0h, got %0h",
						exp_res.blue_level, result.blue_level);
					mismatches++;
				end
			end
		end
	end

	task automatic queue_request(input logic kind, input logic [2:0] ofs, input logic [7:0] data);
		ctp_pkg::request_t req;
		req.kind = kind;
		req.reg_offset = ofs;
		req.write_byte = data;
		pending_requests.push_back(req);
	endtask

	task automatic queue_address(input logic [8:0] addr);
		queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_ADDR_LO, addr[7:0]);
		queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_ADDR_HI,
			{7'($urandom_range(0, 127)), addr[8]});
	endtask

	function automatic logic [8:0] pick_address();
		case ($urandom_range(0, 4))
			0: return 9'($urandom_range(0, TABLE_ENTRIES - 1));
			1: return {5'($urandom_range(0, 31)), 4'b0};
			2: return 9'd0;
			3: return 9'(TABLE_ENTRIES - 1 - $urandom_range(0, 3));
			default: return 9'($urandom_range(0, 40));
		endcase
	endfunction

	task automatic queue_data_burst();
		int n;
		int k;
		n = $urandom_range(1, 6);
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 4))
				0: begin
					queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_DATA_LO, 8'($urandom));
					queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_DATA_HI, 8'($urandom));
				end
				1: begin
					queue_request(ctp_pkg::KIND_READ, ctp_pkg::OFS_DATA_LO, 8'($urandom));
					queue_request(ctp_pkg::KIND_READ, ctp_pkg::OFS_DATA_HI, 8'($urandom));
				end
				2: queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_DATA_LO, 8'($urandom));
				3: queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_DATA_HI, 8'($urandom));
				default: queue_request(ctp_pkg::KIND_READ, ctp_pkg::OFS_DATA_HI, 8'($urandom));
			endcase
		end
	endtask

	initial begin
		int ofs;
		foreach (shadow_table[i])
			shadow_table[i] = '0;

		// reads of every offset on the cleared table, writes to unused offsets
		for (ofs = 0; ofs < 8; ofs++)
			queue_request(ctp_pkg::KIND_READ, 3'(ofs), 8'hFF);
		queue_request(ctp_pkg::KIND_WRITE, 3'd0, 8'hFF);
		queue_request(ctp_pkg::KIND_WRITE, 3'd7, 8'h00);
		// last entry, then wrap to zero
		queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_ADDR_LO, 8'hFF);
		queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_ADDR_HI, 8'hFF);
		queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_DATA_LO, 8'hA5);
		queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_DATA_HI, 8'hFF);
		queue_request(ctp_pkg::KIND_READ, ctp_pkg::OFS_DATA_HI, 8'h00);
		// mirror copy lands on the entry just written
		queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_ADDR_LO, 8'h10);
		queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_ADDR_HI, 8'hFE);
		queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_DATA_LO, 8'h3C);
		queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_DATA_HI, 8'h81);
		// entry zero changes, mirrored to every multiple of the stride
		queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_ADDR_LO, 8'h00);
		queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_ADDR_HI, 8'h00);
		queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_DATA_LO, 8'hFF);
		queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_DATA_HI, 8'h01);
		queue_request(ctp_pkg::KIND_READ, ctp_pkg::OFS_DATA_LO, 8'h00);
		queue_request(ctp_pkg::KIND_READ, ctp_pkg::OFS_DATA_HI, 8'h00);

		while (pending_requests.size() < RANDOM_REQUESTS + 25) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
					queue_address(pick_address());
					queue_data_burst();
				end
				12, 13: begin
					// broken sequence: only one half of the address
					if ($urandom_range(0, 1))
						queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_ADDR_LO, 8'($urandom));
					else
						queue_request(ctp_pkg::KIND_WRITE, ctp_pkg::OFS_ADDR_HI, 8'($urandom));
					queue_data_burst();
				end
				default:
					queue_request(1'($urandom), 3'($urandom), 8'($urandom));
			endcase
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (pending_requests.size() > 0 || start || expected_results.size() > 0)
			@(negedge clk);
		repeat (50) @(posedge clk);

		if (mismatches == 0)
			$display("color_table_port test passed");
		else
			$display("color_table_port test failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("color_table_port test failed");
		$finish;
	end

endmodule
